### hw/rtl/apdu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apdu_pkg: shared types and constants of the APDU command parser
// Parse phases, result beat layout, queue push bundle and status codes.
// ----------------------------------------------------------------------------
package apdu_pkg;

	// Result queue geometry (depth must be a power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

	// Position counter saturates here; only values below it are compared exactly
	localparam logic [2:0] POS_SAT   = 3'd7;
	localparam logic [2:0] POS_LAST_HDR = 3'd3;
	localparam logic [2:0] POS_SHORT_LE = 3'd5;

	// Le encodings of zero
	localparam logic [16:0] SHORT_LE_ZERO = 17'd256;
	localparam logic [16:0] EXT_LE_ZERO   = 17'd65536;

	// Summary status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_LONG  = 2'd2;

	// Case codes
	localparam logic [2:0] CASE_1        = 3'd0;
	localparam logic [2:0] CASE_SHORT_2  = 3'd1;
	localparam logic [2:0] CASE_SHORT_3  = 3'd2;
	localparam logic [2:0] CASE_SHORT_4  = 3'd3;
	localparam logic [2:0] CASE_EXT_2    = 3'd4;
	localparam logic [2:0] CASE_EXT_3    = 3'd5;
	localparam logic [2:0] CASE_EXT_4    = 3'd6;

	// Beat kinds
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [3:0] {
		PH_HDR,
		PH_B0,
		PH_Z1,
		PH_Z2,
		PH_Z3,
		PH_SDATA,
		PH_EDATA,
		PH_ELE1,
		PH_ELE2,
		PH_DONES,
		PH_DONEE
	} phase_t;

	typedef struct packed {
		logic        out_kind;
		logic [7:0]  data_byte;
		logic [7:0]  class_byte;
		logic [7:0]  instr_byte;
		logic [7:0]  param_one;
		logic [7:0]  param_two;
		logic [2:0]  case_code;
		logic [15:0] command_length;
		logic [16:0] expected_length;
		logic [1:0]  status;
		logic        is_final;
	} result_t;

	// Up to two beats per parsed byte: data first, then summary
	typedef struct packed {
		logic    data_en;
		logic    sum_en;
		result_t data;
		result_t sum;
	} push_t;

	typedef struct packed {
		logic               room;
		logic [LEVEL_W-1:0] level;
	} q_status_t;

endpackage
`default_nettype wire

### hw/rtl/apdu_command_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apdu_command_parser_unit: ISO 7816-4 command APDU parser, top level
// Takes raw command APDU bytes and emits data beats and a summary beat.
// ----------------------------------------------------------------------------
// One byte is accepted every cycle while in_stall is low. Each byte is
// registered in the input register and parsed there; its beats are then
// written into the result queue that drives the output. A byte that
// carries in_last gives a data beat (if it is command data) followed by the
// summary beat; both go through that four-beat queue, and input
// stalls only while that queue cannot take two more beats. Summary beats
// carry the header, case code, Lc, Le and status; bytes past a complete
// APDU that already has both command data and Le are dropped and reported
// as too long.
module apdu_command_parser_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        in_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             out_kind,
	output logic [7:0]       data_byte,
	output logic [7:0]       class_byte,
	output logic [7:0]       instr_byte,
	output logic [7:0]       param_one,
	output logic [7:0]       param_two,
	output logic [2:0]       case_code,
	output logic [15:0]      command_length,
	output logic [16:0]      expected_length,
	output logic [1:0]       status,
	output logic             is_final
);
	import apdu_pkg::*;

	push_t     push;
	q_status_t q_status;
	result_t   head;

	apdu_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_status (q_status),
		.push     (push)
	);

	apdu_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.q_status  (q_status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	// Drive the output beat from the queue head
	assign out_kind        = head.out_kind;
	assign data_byte       = head.data_byte;
	assign class_byte      = head.class_byte;
	assign instr_byte      = head.instr_byte;
	assign param_one       = head.param_one;
	assign param_two       = head.param_two;
	assign case_code       = head.case_code;
	assign command_length  = head.command_length;
	assign expected_length = head.expected_length;
	assign status          = head.status;
	assign is_final        = head.is_final;

`ifndef SYNTH
	// Queue never overfills
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.level <= LEVEL_W'(QUEUE_DEPTH))
		else $error("result queue level above depth");

	// Beats are only pushed when two slots are free
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.data_en || push.sum_en) |-> q_status.room)
		else $error("beat pushed without queue room");

	// Input stalls only when the queue is short of room
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> !q_status.room)
		else $error("input stalled with queue room");

	// A data beat pushed with a summary is never marked final
	a_data_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		(push.data_en && push.sum_en) |-> !push.data.is_final)
		else $error("data beat final ahead of summary");
`endif

endmodule
`default_nettype wire

### hw/rtl/apdu_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apdu_out_queue: result beat queue
// Small register queue taking up to two beats per cycle and handing one
// beat per cycle to the output channel while out_stall is low.
// ----------------------------------------------------------------------------
module apdu_out_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire apdu_pkg::push_t    push,
	output apdu_pkg::q_status_t     q_status,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output apdu_pkg::result_t       head
);
	import apdu_pkg::*;

	result_t            mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  head_q;
	logic [QPTR_W-1:0]  tail_q;
	logic [LEVEL_W-1:0] level_q;
	logic               pop;
	logic [LEVEL_W-1:0] n_push;
	logic [QPTR_W-1:0]  sum_ptr;

	assign out_valid = (level_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = mem[head_q];
	assign n_push    = LEVEL_W'(push.data_en) + LEVEL_W'(push.sum_en);
	assign sum_ptr   = push.data_en ? tail_q + QPTR_W'(1) : tail_q;

	// Leave room for a data beat plus a summary beat
	assign q_status.room  = (level_q <= LEVEL_W'(QUEUE_DEPTH - 2));
	assign q_status.level = level_q;

	// Store pushed beats
	always_ff @(posedge clk) begin
		if (push.data_en) begin
			mem[tail_q] <= push.data;
		end
		if (push.sum_en) begin
			mem[sum_ptr] <= push.sum;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			level_q <= '0;
		end else begin
			tail_q  <= tail_q + QPTR_W'(n_push);
			if (pop) begin
				head_q <= head_q + QPTR_W'(1);
			end
			level_q <= level_q + n_push - LEVEL_W'(pop);
		end
	end

endmodule
`default_nettype wire

### hw/rtl/apdu_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apdu_parser: byte input register and APDU phase logic
// Registers each incoming byte, steps the parse phase and builds the data
// beat and the end-of-APDU summary beat for the result queue.
// ----------------------------------------------------------------------------
module apdu_parser (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          in_byte,
	input  wire logic                in_last,
	input  wire apdu_pkg::q_status_t q_status,
	output apdu_pkg::push_t          push
);
	import apdu_pkg::*;

	// Input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Parse state
	phase_t      phase_q, phase_d;
	logic [2:0]  pos_q, pos_d;
	logic [7:0]  hdr_q [4];
	logic [7:0]  hdr_d [4];
	logic [7:0]  fbb_q, fbb_d;
	logic [15:0] lc_q, lc_d;
	logic [16:0] le_q, le_d;
	logic [15:0] rem_q, rem_d;
	logic        long_q, long_d;
	logic        fwd;

	logic        accept;
	logic        advance;
	logic [15:0] rem_dec;
	logic [15:0] le_lo;

	// Summary fields
	logic [2:0]  cse;
	logic [15:0] lc_sum;
	logic [16:0] le_sum;
	logic [1:0]  st;

	assign advance  = valid_s1 && q_status.room;
	assign in_stall = valid_s1 && !q_status.room;
	assign accept   = in_valid && !in_stall;

	// Load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	assign rem_dec = (rem_q != '0) ? rem_q - 16'd1 : rem_q;
	assign le_lo   = {le_q[15:8], byte_s1};

	// Step the parse phase for the byte in the input register
	always_comb begin
		phase_d = phase_q;
		pos_d   = (pos_q != POS_SAT) ? pos_q + 3'd1 : pos_q;
		for (int i = 0; i < 4; i++) begin
			hdr_d[i] = hdr_q[i];
		end
		fbb_d  = fbb_q;
		lc_d   = lc_q;
		le_d   = le_q;
		rem_d  = rem_q;
		long_d = long_q;
		fwd    = 1'b0;
		unique case (phase_q)
			PH_HDR: begin
				hdr_d[pos_q[1:0]] = byte_s1;
				if (pos_q >= POS_LAST_HDR) begin
					phase_d = PH_B0;
				end
			end
			PH_B0: begin
				fbb_d = byte_s1;
				if (byte_s1 == 8'd0) begin
					phase_d = PH_Z1;
				end else begin
					lc_d    = {8'd0, byte_s1};
					rem_d   = {8'd0, byte_s1};
					phase_d = PH_SDATA;
				end
			end
			PH_Z1: begin
				lc_d    = {byte_s1, 8'd0};
				phase_d = PH_Z2;
			end
			PH_Z2: begin
				lc_d    = {lc_q[15:8], byte_s1};
				phase_d = PH_Z3;
			end
			PH_Z3: begin
				if (lc_q == '0) begin
					rem_d   = lc_q;
					le_d    = {1'b0, byte_s1, 8'd0};
					phase_d = PH_ELE2;
				end else begin
					fwd     = 1'b1;
					rem_d   = lc_q - 16'd1;
					phase_d = (lc_q == 16'd1) ? PH_ELE1 : PH_EDATA;
				end
			end
			PH_SDATA: begin
				if (rem_q != '0) begin
					fwd   = 1'b1;
					rem_d = rem_dec;
				end else begin
					le_d    = (byte_s1 == 8'd0) ? SHORT_LE_ZERO : {9'd0, byte_s1};
					phase_d = PH_DONES;
				end
			end
			PH_EDATA: begin
				fwd   = 1'b1;
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					phase_d = PH_ELE1;
				end
			end
			PH_ELE1: begin
				le_d    = {1'b0, byte_s1, 8'd0};
				phase_d = PH_ELE2;
			end
			PH_ELE2: begin
				le_d    = (le_lo == '0) ? EXT_LE_ZERO : {1'b0, le_lo};
				phase_d = PH_DONEE;
			end
			default: begin
				// APDU with data and Le already complete: flag overflow, drop byte
				long_d = 1'b1;
			end
		endcase
	end

	// Work out case, lengths and status from the updated state
	always_comb begin
		cse    = CASE_1;
		lc_sum = '0;
		le_sum = '0;
		st     = ST_OK;
		unique case (phase_d)
			PH_HDR:   st = ST_SHORT;
			PH_B0:    cse = CASE_1;
			PH_Z1: begin
				cse    = CASE_SHORT_2;
				le_sum = SHORT_LE_ZERO;
			end
			PH_Z2: begin
				cse    = CASE_SHORT_4;
				le_sum = (lc_d[15:8] == 8'd0) ? SHORT_LE_ZERO : {9'd0, lc_d[15:8]};
			end
			PH_Z3: begin
				cse    = CASE_EXT_2;
				le_sum = (lc_d == '0) ? EXT_LE_ZERO : {1'b0, lc_d};
			end
			PH_SDATA: begin
				if (pos_d == POS_SHORT_LE) begin
					cse    = CASE_SHORT_2;
					le_sum = {9'd0, fbb_d};
				end else if (rem_d != '0) begin
					st = ST_SHORT;
				end else begin
					cse    = CASE_SHORT_3;
					lc_sum = lc_d;
				end
			end
			PH_EDATA: st = ST_SHORT;
			PH_ELE1: begin
				cse    = CASE_EXT_3;
				lc_sum = lc_d;
			end
			PH_ELE2:  st = ST_SHORT;
			PH_DONES: begin
				cse    = CASE_SHORT_4;
				lc_sum = lc_d;
				le_sum = le_d;
			end
			PH_DONEE: begin
				cse    = CASE_EXT_4;
				lc_sum = lc_d;
				le_sum = le_d;
			end
			default:  st = ST_SHORT;
		endcase
		if (st == ST_OK && long_d) begin
			st = ST_LONG;
		end
		if (st == ST_SHORT) begin
			cse    = CASE_1;
			lc_sum = '0;
			le_sum = '0;
		end
	end

	// Build the beats for the queue
	always_comb begin
		push.data_en              = advance && fwd;
		push.sum_en               = advance && last_s1;
		push.data                 = '0;
		push.data.out_kind        = KIND_DATA;
		push.data.data_byte       = byte_s1;
		push.data.is_final        = !last_s1;
		push.sum                  = '0;
		push.sum.out_kind         = KIND_SUMMARY;
		push.sum.class_byte       = hdr_d[0];
		push.sum.instr_byte       = hdr_d[1];
		push.sum.param_one        = hdr_d[2];
		push.sum.param_two        = hdr_d[3];
		push.sum.case_code        = cse;
		push.sum.command_length   = lc_sum;
		push.sum.expected_length  = le_sum;
		push.sum.status           = st;
		push.sum.is_final         = 1'b1;
	end

	// Commit parse state; the last byte returns the parser to its start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			pos_q   <= '0;
			for (int i = 0; i < 4; i++) begin
				hdr_q[i] <= '0;
			end
			fbb_q  <= '0;
			lc_q   <= '0;
			le_q   <= '0;
			rem_q  <= '0;
			long_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= PH_HDR;
				pos_q   <= '0;
				for (int i = 0; i < 4; i++) begin
					hdr_q[i] <= '0;
				end
				fbb_q  <= '0;
				lc_q   <= '0;
				le_q   <= '0;
				rem_q  <= '0;
				long_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				for (int i = 0; i < 4; i++) begin
					hdr_q[i] <= hdr_d[i];
				end
				fbb_q  <= fbb_d;
				lc_q   <= lc_d;
				le_q   <= le_d;
				rem_q  <= rem_d;
				long_q <= long_d;
			end
		end
	end

endmodule
`default_nettype wire
